>>> src/tkf_pkg.sv
`default_nettype none

package tkf_pkg;

	localparam int FRAC_W = 24;
	localparam int CFG_W  = 31;
	localparam int IDX_W  = 2;
	// magnitude of num << 24
	localparam int DVD_W  = 32 + FRAC_W;
	// two quotient bits per cycle
	localparam int DIV_CYCLES = DVD_W / 2;

	typedef logic signed [31:0] tkf_q_t;

	localparam tkf_q_t ONE_Q = 32'sd16777216;
	localparam tkf_q_t MAX_Q = 32'sh7FFFFFFF;
	localparam tkf_q_t MIN_Q = 32'sh80000000;

	localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd16777;
	localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 31'd50332;
	localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 31'd8388608;
	localparam logic [CFG_W-1:0] STEP_TIME_RST   = 31'd167772;

	localparam logic [IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;
	localparam logic [IDX_W-1:0] CFG_STEP_TIME   = 2'd3;

	// sequencer steps, in program order
	typedef enum logic [4:0] {
		ST_IDLE, ST_GB, ST_GBM, ST_ANG1, ST_D0, ST_D0M, ST_PAA1, ST_D1, ST_D1M,
		ST_PAB1, ST_PBA1, ST_QBM, ST_PBB1, ST_ERR, ST_E, ST_K0, ST_K1,
		ST_M00, ST_PAA2, ST_M01, ST_PAB2, ST_M10, ST_PBA2, ST_M11, ST_PBB2,
		ST_MA, ST_ANG2, ST_MB, ST_BIAS2, ST_RATE
	} tkf_state_t;

	typedef enum logic [2:0] {
		K_NONE, K_ADD, K_SUB, K_D0, K_MUL, K_DIV
	} tkf_kind_t;

	typedef enum logic [4:0] {
		OPD_ZERO, OPD_GYRO, OPD_MEAS, OPD_ANG, OPD_BIAS, OPD_PAA, OPD_PAB, OPD_PBA,
		OPD_PBB, OPD_TMP, OPD_ERR, OPD_E, OPD_K0, OPD_K1, OPD_T0, OPD_T1,
		OPD_QA, OPD_QB, OPD_RN, OPD_DT
	} tkf_opnd_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_TMP, DST_ANG, DST_BIAS, DST_PAA, DST_PAB, DST_PBA, DST_PBB,
		DST_ERR, DST_E, DST_K0, DST_K1, DST_RATE
	} tkf_dest_t;

	typedef struct packed {
		tkf_kind_t kind;
		tkf_opnd_t a;
		tkf_opnd_t b;
		tkf_dest_t dst;
		logic      snap;
		logic      mul_go;
		logic      div_go;
		logic      wr;
	} tkf_uop_t;

	typedef struct packed {
		logic   go;
		tkf_q_t num;
		tkf_q_t den;
	} tkf_div_req_t;

endpackage

`default_nettype wire

>>> src/tkf_mul.sv
`default_nettype none

module tkf_mul (
	input  wire logic           clk,
	input  wire logic           go,
	input  wire tkf_pkg::tkf_q_t a,
	input  wire tkf_pkg::tkf_q_t b,
	output tkf_pkg::tkf_q_t     res
);

	logic signed [63:0] prod_s1;
	logic signed [63:0] rnd;
	logic signed [39:0] shr;

	always_ff @(posedge clk) begin
		if (go) begin
			prod_s1 <= 64'(a) * 64'(b);
		end
	end

	// round half up, then clamp to 32 bits
	always_comb begin
		rnd = prod_s1 + (64'sd1 <<< (tkf_pkg::FRAC_W - 1));
		shr = rnd[63:tkf_pkg::FRAC_W];
		if (shr[39:31] == {9{shr[39]}}) begin
			res = shr[31:0];
		end else if (shr[39]) begin
			res = tkf_pkg::MIN_Q;
		end else begin
			res = tkf_pkg::MAX_Q;
		end
	end

endmodule

`default_nettype wire

>>> src/tkf_div.sv
`default_nettype none

module tkf_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tkf_pkg::tkf_div_req_t req,
	output logic                      done,
	output tkf_pkg::tkf_q_t           quot
);

	localparam int DW = tkf_pkg::DVD_W;
	localparam logic [4:0] LAST = 5'(tkf_pkg::DIV_CYCLES - 1);

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic          neg_q;
	logic [31:0]   rem_q;
	logic [31:0]   dmag_q;
	logic [DW-1:0] dvd_q;

	logic [31:0]   nmag;
	logic [31:0]   dmag;
	logic [31:0]   rem_d;
	logic [DW-1:0] dvd_d;
	logic [32:0]   trial;

	assign nmag = req.num[31] ? (~req.num + 32'd1) : req.num;
	assign dmag = req.den[31] ? (~req.den + 32'd1) : req.den;

	// two restoring steps; quotient bits shift in behind the dividend
	always_comb begin
		rem_d = rem_q;
		dvd_d = dvd_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_d, dvd_d[DW-1]};
			dvd_d = {dvd_d[DW-2:0], 1'b0};
			if (trial >= {1'b0, dmag_q}) begin
				trial    = trial - {1'b0, dmag_q};
				dvd_d[0] = 1'b1;
			end
			rem_d = trial[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				if (req.den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q  <= '0;
			dmag_q <= dmag;
			if (req.den == '0) begin
				// zero divisor: all ones clamps to the limit of the numerator's sign
				neg_q <= req.num[31];
				dvd_q <= (req.num == '0) ? '0 : '1;
			end else begin
				neg_q <= req.num[31] ^ req.den[31];
				dvd_q <= {nmag, {tkf_pkg::FRAC_W{1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= rem_d;
			dvd_q <= dvd_d;
		end
	end

	always_comb begin
		if (!neg_q) begin
			quot = (dvd_q > DW'(32'h7FFFFFFF)) ? tkf_pkg::MAX_Q : dvd_q[31:0];
		end else begin
			quot = (dvd_q > DW'(32'h80000000)) ? tkf_pkg::MIN_Q : (~dvd_q[31:0] + 32'd1);
		end
	end

	assign done = done_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q)
		else $error("divider started while busy");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == LAST && !req.go) |=> (done_q && !busy_q))
		else $error("divider missed its last step");

endmodule

`default_nettype wire

>>> src/tkf_seq.sv
`default_nettype none

module tkf_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          div_done,
	input  wire logic          out_free,
	output tkf_pkg::tkf_uop_t  uop,
	output logic               busy
);

	tkf_pkg::tkf_state_t state_q, state_d, step;
	logic                phase_q, phase_d;

	function automatic tkf_pkg::tkf_uop_t mk(
		input tkf_pkg::tkf_kind_t k,
		input tkf_pkg::tkf_opnd_t a,
		input tkf_pkg::tkf_opnd_t b,
		input tkf_pkg::tkf_dest_t d
	);
		tkf_pkg::tkf_uop_t u;
		u        = '0;
		u.kind   = k;
		u.a      = a;
		u.b      = b;
		u.dst    = d;
		return u;
	endfunction

	assign step = tkf_pkg::tkf_state_t'(state_q + 5'd1);
	assign busy = (state_q != tkf_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkf_pkg::ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = 1'b0;
		case (uop.kind)
			tkf_pkg::K_NONE: begin
				if (start) state_d = tkf_pkg::ST_GB;
			end
			tkf_pkg::K_MUL: begin
				if (phase_q) state_d = step;
				else phase_d = 1'b1;
			end
			tkf_pkg::K_DIV: begin
				if (phase_q && div_done) state_d = step;
				else phase_d = 1'b1;
			end
			default: begin
				if (uop.dst != tkf_pkg::DST_RATE) state_d = step;
				else if (out_free) state_d = tkf_pkg::ST_IDLE;
			end
		endcase
	end

	// step decode
	always_comb begin
		case (state_q)
			tkf_pkg::ST_GB:    uop = mk(tkf_pkg::K_SUB, tkf_pkg::OPD_GYRO, tkf_pkg::OPD_BIAS,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_GBM:   uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_TMP, tkf_pkg::OPD_DT,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_ANG1:  uop = mk(tkf_pkg::K_ADD, tkf_pkg::OPD_ANG, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_ANG);
			tkf_pkg::ST_D0:    uop = mk(tkf_pkg::K_D0, tkf_pkg::OPD_QA, tkf_pkg::OPD_PAB,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_D0M:   uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_TMP, tkf_pkg::OPD_DT,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_PAA1:  uop = mk(tkf_pkg::K_ADD, tkf_pkg::OPD_PAA, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_PAA);
			tkf_pkg::ST_D1:    uop = mk(tkf_pkg::K_SUB, tkf_pkg::OPD_ZERO, tkf_pkg::OPD_PBB,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_D1M:   uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_TMP, tkf_pkg::OPD_DT,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_PAB1:  uop = mk(tkf_pkg::K_ADD, tkf_pkg::OPD_PAB, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_PAB);
			tkf_pkg::ST_PBA1:  uop = mk(tkf_pkg::K_ADD, tkf_pkg::OPD_PBA, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_PBA);
			tkf_pkg::ST_QBM:   uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_QB, tkf_pkg::OPD_DT,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_PBB1:  uop = mk(tkf_pkg::K_ADD, tkf_pkg::OPD_PBB, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_PBB);
			tkf_pkg::ST_ERR:   uop = mk(tkf_pkg::K_SUB, tkf_pkg::OPD_MEAS, tkf_pkg::OPD_ANG,
				tkf_pkg::DST_ERR);
			tkf_pkg::ST_E:     uop = mk(tkf_pkg::K_ADD, tkf_pkg::OPD_RN, tkf_pkg::OPD_PAA,
				tkf_pkg::DST_E);
			tkf_pkg::ST_K0:    uop = mk(tkf_pkg::K_DIV, tkf_pkg::OPD_PAA, tkf_pkg::OPD_E,
				tkf_pkg::DST_K0);
			tkf_pkg::ST_K1:    uop = mk(tkf_pkg::K_DIV, tkf_pkg::OPD_PBA, tkf_pkg::OPD_E,
				tkf_pkg::DST_K1);
			tkf_pkg::ST_M00:   uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_K0, tkf_pkg::OPD_T0,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_PAA2:  uop = mk(tkf_pkg::K_SUB, tkf_pkg::OPD_PAA, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_PAA);
			tkf_pkg::ST_M01:   uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_K0, tkf_pkg::OPD_T1,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_PAB2:  uop = mk(tkf_pkg::K_SUB, tkf_pkg::OPD_PAB, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_PAB);
			tkf_pkg::ST_M10:   uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_K1, tkf_pkg::OPD_T0,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_PBA2:  uop = mk(tkf_pkg::K_SUB, tkf_pkg::OPD_PBA, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_PBA);
			tkf_pkg::ST_M11:   uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_K1, tkf_pkg::OPD_T1,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_PBB2:  uop = mk(tkf_pkg::K_SUB, tkf_pkg::OPD_PBB, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_PBB);
			tkf_pkg::ST_MA:    uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_K0, tkf_pkg::OPD_ERR,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_ANG2:  uop = mk(tkf_pkg::K_ADD, tkf_pkg::OPD_ANG, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_ANG);
			tkf_pkg::ST_MB:    uop = mk(tkf_pkg::K_MUL, tkf_pkg::OPD_K1, tkf_pkg::OPD_ERR,
				tkf_pkg::DST_TMP);
			tkf_pkg::ST_BIAS2: uop = mk(tkf_pkg::K_ADD, tkf_pkg::OPD_BIAS, tkf_pkg::OPD_TMP,
				tkf_pkg::DST_BIAS);
			tkf_pkg::ST_RATE:  uop = mk(tkf_pkg::K_SUB, tkf_pkg::OPD_GYRO, tkf_pkg::OPD_BIAS,
				tkf_pkg::DST_RATE);
			default:           uop = mk(tkf_pkg::K_NONE, tkf_pkg::OPD_ZERO, tkf_pkg::OPD_ZERO,
				tkf_pkg::DST_NONE);
		endcase
		uop.snap   = (state_q == tkf_pkg::ST_E);
		uop.mul_go = (uop.kind == tkf_pkg::K_MUL) && !phase_q;
		uop.div_go = (uop.kind == tkf_pkg::K_DIV) && !phase_q;
		case (uop.kind)
			tkf_pkg::K_NONE: uop.wr = 1'b0;
			tkf_pkg::K_MUL:  uop.wr = phase_q;
			tkf_pkg::K_DIV:  uop.wr = phase_q && div_done;
			default:         uop.wr = (uop.dst != tkf_pkg::DST_RATE) || out_free;
		endcase
	end

endmodule

`default_nettype wire

>>> src/tilt_kalman_filter_core.sv
`default_nettype none

// channel  dir  beat qualifier        payload
// in       in   in_valid & !in_stall   meas_angle, gyro_rate
// out      out  out_valid & !out_stall angle_estimate, rate_estimate
// cfg      in   cfg_valid & cfg_ready  cfg_index, cfg_data
//
// A zero divisor (angle variance plus measurement noise) skips the divider's restoring steps.
// Two gain divisions (issue, 28 steps of two quotient bits, write) dominate the run;
// ten products share one multiplier, each issued and then written from its product register.
// in_stall is high from the accepted beat until the result is loaded into the
// output register; a result held by out_stall does not block the next beat.
// Reset clears the estimates, sets the covariance to identity and loads the
// default noise and step settings.

module tilt_kalman_filter_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [31:0]           meas_angle,
	input  wire logic signed [31:0]           gyro_rate,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [31:0]                angle_estimate,
	output logic signed [31:0]                rate_estimate,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tkf_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [tkf_pkg::CFG_W-1:0]    cfg_data
);

	tkf_pkg::tkf_uop_t     uop;
	tkf_pkg::tkf_div_req_t div_req;
	logic                  busy;
	logic                  start;
	logic                  out_free;
	logic                  div_done;
	tkf_pkg::tkf_q_t       div_quot;
	tkf_pkg::tkf_q_t       mul_res;

	logic [tkf_pkg::CFG_W-1:0] qa_q, qb_q, rn_q, dt_q;
	tkf_pkg::tkf_q_t ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
	tkf_pkg::tkf_q_t gyro_q, meas_q, tmp_q, err_q, e_q, k0_q, k1_q, t0_q, t1_q;
	tkf_pkg::tkf_q_t angle_out_q, rate_out_q;
	logic            out_valid_q;

	tkf_pkg::tkf_q_t     opa, opb, alu_sat, res;
	logic signed [33:0]  alu34;

	function automatic tkf_pkg::tkf_q_t pick(
		input tkf_pkg::tkf_opnd_t s,
		input tkf_pkg::tkf_q_t    gy, me, an, bi, aa, ab, ba, bb, tm, er, ee, g0, g1, c0, c1,
		input logic [tkf_pkg::CFG_W-1:0] qa, qb, rn, dt
	);
		tkf_pkg::tkf_q_t v;
		case (s)
			tkf_pkg::OPD_GYRO: v = gy;
			tkf_pkg::OPD_MEAS: v = me;
			tkf_pkg::OPD_ANG:  v = an;
			tkf_pkg::OPD_BIAS: v = bi;
			tkf_pkg::OPD_PAA:  v = aa;
			tkf_pkg::OPD_PAB:  v = ab;
			tkf_pkg::OPD_PBA:  v = ba;
			tkf_pkg::OPD_PBB:  v = bb;
			tkf_pkg::OPD_TMP:  v = tm;
			tkf_pkg::OPD_ERR:  v = er;
			tkf_pkg::OPD_E:    v = ee;
			tkf_pkg::OPD_K0:   v = g0;
			tkf_pkg::OPD_K1:   v = g1;
			tkf_pkg::OPD_T0:   v = c0;
			tkf_pkg::OPD_T1:   v = c1;
			tkf_pkg::OPD_QA:   v = {1'b0, qa};
			tkf_pkg::OPD_QB:   v = {1'b0, qb};
			tkf_pkg::OPD_RN:   v = {1'b0, rn};
			tkf_pkg::OPD_DT:   v = {1'b0, dt};
			default:           v = '0;
		endcase
		return v;
	endfunction

	assign start     = in_valid && !busy;
	assign in_stall  = busy;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	tkf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.div_done (div_done),
		.out_free (out_free),
		.uop      (uop),
		.busy     (busy)
	);

	always_comb begin
		opa = pick(uop.a, gyro_q, meas_q, ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q, tmp_q,
			err_q, e_q, k0_q, k1_q, t0_q, t1_q, qa_q, qb_q, rn_q, dt_q);
		opb = pick(uop.b, gyro_q, meas_q, ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q, tmp_q,
			err_q, e_q, k0_q, k1_q, t0_q, t1_q, qa_q, qb_q, rn_q, dt_q);
	end

	tkf_mul u_mul (
		.clk (clk),
		.go  (uop.mul_go),
		.a   (opa),
		.b   (opb),
		.res (mul_res)
	);

	assign div_req.go  = uop.div_go;
	assign div_req.num = opa;
	assign div_req.den = opb;

	tkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// saturating add/sub; the angle-variance drift subtracts both cross terms at once
	always_comb begin
		case (uop.kind)
			tkf_pkg::K_ADD: alu34 = 34'(opa) + 34'(opb);
			tkf_pkg::K_SUB: alu34 = 34'(opa) - 34'(opb);
			tkf_pkg::K_D0:  alu34 = 34'(opa) - 34'(opb) - 34'(pba_q);
			default:        alu34 = '0;
		endcase
		if (alu34[33:31] == {3{alu34[33]}}) begin
			alu_sat = alu34[31:0];
		end else if (alu34[33]) begin
			alu_sat = tkf_pkg::MIN_Q;
		end else begin
			alu_sat = tkf_pkg::MAX_Q;
		end
		case (uop.kind)
			tkf_pkg::K_MUL: res = mul_res;
			tkf_pkg::K_DIV: res = div_quot;
			default:        res = alu_sat;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= tkf_pkg::ANGLE_NOISE_RST;
			qb_q <= tkf_pkg::BIAS_NOISE_RST;
			rn_q <= tkf_pkg::MEAS_NOISE_RST;
			dt_q <= tkf_pkg::STEP_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tkf_pkg::CFG_ANGLE_NOISE: qa_q <= cfg_data;
				tkf_pkg::CFG_BIAS_NOISE:  qb_q <= cfg_data;
				tkf_pkg::CFG_MEAS_NOISE:  rn_q <= cfg_data;
				tkf_pkg::CFG_STEP_TIME:   dt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q       <= '0;
			bias_q      <= '0;
			paa_q       <= tkf_pkg::ONE_Q;
			pab_q       <= '0;
			pba_q       <= '0;
			pbb_q       <= tkf_pkg::ONE_Q;
			out_valid_q <= 1'b0;
		end else begin
			if (uop.wr) begin
				case (uop.dst)
					tkf_pkg::DST_ANG:  ang_q  <= res;
					tkf_pkg::DST_BIAS: bias_q <= res;
					tkf_pkg::DST_PAA:  paa_q  <= res;
					tkf_pkg::DST_PAB:  pab_q  <= res;
					tkf_pkg::DST_PBA:  pba_q  <= res;
					tkf_pkg::DST_PBB:  pbb_q  <= res;
					default: ;
				endcase
			end
			if (uop.wr && uop.dst == tkf_pkg::DST_RATE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gyro_q <= gyro_rate;
			meas_q <= meas_angle;
		end
		if (uop.snap) begin
			t0_q <= paa_q;
			t1_q <= pab_q;
		end
		if (uop.wr) begin
			case (uop.dst)
				tkf_pkg::DST_TMP: tmp_q <= res;
				tkf_pkg::DST_ERR: err_q <= res;
				tkf_pkg::DST_E:   e_q   <= res;
				tkf_pkg::DST_K0:  k0_q  <= res;
				tkf_pkg::DST_K1:  k1_q  <= res;
				tkf_pkg::DST_RATE: begin
					rate_out_q  <= res;
					angle_out_q <= ang_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign angle_estimate = angle_out_q;
	assign rate_estimate  = rate_out_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy)
		else $error("accepted beat did not start the sequencer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(uop.wr && uop.dst == tkf_pkg::DST_RATE) |-> out_free)
		else $error("result written over a held output");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(uop.wr && uop.dst == tkf_pkg::DST_RATE))
		else $error("output valid without a result");

endmodule

`default_nettype wire
